/* rtl/core/bfpa_pkg.sv */
`default_nettype none
package bfpa_pkg;
	localparam int MaxBlocks = 64;
	localparam int PageCount = 32768;
	localparam int IdxW = $clog2(MaxBlocks);
	localparam int CntW = IdxW + 1;
	localparam int BaseW = 15;
	localparam int LenW = 16;

	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_ALLOC = 2'd1;
	localparam logic [1:0] FUNC_REL = 2'd2;
	localparam logic [1:0] FUNC_NOP = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_ZERO = 2'd3;

	typedef struct packed {
		logic [BaseW-1:0] start;
		logic [LenW-1:0] len;
	} blk_t;

	// memory port bundle from sequencer to table
	typedef struct packed {
		logic re;
		logic [IdxW-1:0] raddr;
		logic we;
		logic [IdxW-1:0] waddr;
		blk_t wdata;
	} mem_req_t;
endpackage
`default_nettype wire

/* rtl/core/bfpa_table.sv */
`default_nettype none
module bfpa_table (
	input wire logic clk,
	input wire bfpa_pkg::mem_req_t req,
	output bfpa_pkg::blk_t rdata
);
	bfpa_pkg::blk_t mem [bfpa_pkg::MaxBlocks];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (req.we) mem[req.waddr] <= req.wdata;
		if (req.re) rdata <= mem[req.raddr];
	end
endmodule
`default_nettype wire

/* rtl/core/bfpa_seq.sv */
`default_nettype none
module bfpa_seq (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] func,
	input wire logic [14:0] base,
	input wire logic [15:0] count,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] status,
	output logic [14:0] page,
	output logic [15:0] pages_free,
	output bfpa_pkg::mem_req_t req,
	input wire bfpa_pkg::blk_t rdata
);
	localparam int IdxW = bfpa_pkg::IdxW;
	localparam int CntW = bfpa_pkg::CntW;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_DECIDE, S_NEXT, S_SHUP, S_SHDN, S_FIX, S_DONE
	} state_t;

	state_t state_q;
	logic [1:0] func_q;
	logic [14:0] base_q;
	logic [15:0] cnt_q;
	logic [CntW-1:0] nblk_q;
	logic [15:0] total_q;
	logic [CntW-1:0] i_q;       // scan index of the entry being requested
	logic rdv_q;                // rdata holds entry i_q-1
	logic [CntW-1:0] pos_q;     // insert slot or best index
	logic pos_found_q;
	bfpa_pkg::blk_t prev_q;     // entry pos-1 (release)
	bfpa_pkg::blk_t nxt_q;      // entry pos (release)
	logic nxt_ok_q;
	logic found_q;
	logic [15:0] best_len_q;
	logic [14:0] best_start_q;
	bfpa_pkg::blk_t ins_q;      // entry written at pos after shift
	logic [CntW-1:0] k_q;
	logic [CntW-1:0] stop_q;
	logic [1:0] st_q;           // status of the operation in progress
	logic [14:0] pg_q;          // page of the operation in progress
	logic wr_we_q;
	logic [IdxW-1:0] wr_addr_q;
	bfpa_pkg::blk_t wr_data_q;

	logic rd_re;
	logic [IdxW-1:0] rd_addr;
	logic [CntW-1:0] ridx;
	logic [16:0] psum, nsum, plen, nlen;
	logic pm, nm;
	logic [14:0] cur_start;
	logic [16:0] cur_len;
	logic [16:0] tsum;

	assign in_stall = (state_q != S_IDLE);
	assign ridx = i_q - CntW'(1);

	// issue reads in the cycle before the data is used
	always_comb begin
		rd_re = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			S_SCAN: begin
				rd_re = (i_q < nblk_q);
				rd_addr = i_q[IdxW-1:0];
			end
			S_NEXT: begin
				rd_re = (k_q < stop_q);
				rd_addr = IdxW'(k_q + CntW'(1));
			end
			S_SHUP: begin
				rd_re = (k_q > stop_q);
				rd_addr = IdxW'(k_q - CntW'(1));
			end
			default: begin
				rd_re = 1'b0;
				rd_addr = '0;
			end
		endcase
		req = '{re: rd_re, raddr: rd_addr, we: wr_we_q, waddr: wr_addr_q, wdata: wr_data_q};
	end

	// release merge decisions from the two neighbors
	always_comb begin
		psum = 17'(prev_q.start) + 17'(prev_q.len);
		plen = 17'(prev_q.len) + 17'(cnt_q);
		pm = (pos_q != '0) && (psum == 17'(base_q)) && (plen <= 17'hFFFF);
		cur_start = pm ? prev_q.start : base_q;
		cur_len = pm ? plen : 17'(cnt_q);
		nsum = 17'(cur_start) + cur_len;
		nlen = cur_len + 17'(nxt_q.len);
		nm = nxt_ok_q && (nsum == 17'(nxt_q.start)) && (nlen <= 17'hFFFF);
		tsum = 17'(total_q) + 17'(cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			nblk_q <= '0;
			total_q <= '0;
			wr_we_q <= 1'b0;
			wr_addr_q <= '0;
			wr_data_q <= '0;
			status <= '0;
			page <= '0;
			pages_free <= '0;
		end else begin
			wr_we_q <= 1'b0;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q <= func;
						base_q <= base;
						cnt_q <= count;
						i_q <= '0;
						rdv_q <= 1'b0;
						pos_q <= nblk_q;
						pos_found_q <= 1'b0;
						found_q <= 1'b0;
						nxt_ok_q <= 1'b0;
						pg_q <= '0;
						st_q <= bfpa_pkg::ST_OK;
						if (func == bfpa_pkg::FUNC_NOP) begin
							state_q <= S_DONE;
						end else if (count == '0) begin
							st_q <= bfpa_pkg::ST_ZERO;
							state_q <= S_DONE;
						end else if (func == bfpa_pkg::FUNC_ADD &&
							nblk_q >= CntW'(bfpa_pkg::MaxBlocks)) begin
							st_q <= bfpa_pkg::ST_FULL;
							state_q <= S_DONE;
						end else if (func == bfpa_pkg::FUNC_ALLOC &&
							(count > total_q || 32'(count) > 32'(bfpa_pkg::PageCount))) begin
							st_q <= bfpa_pkg::ST_NOFIT;
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				// stream entries; rdata arrives in the cycle after its request
				S_SCAN: begin
					i_q <= i_q + CntW'(1);
					rdv_q <= (i_q < nblk_q);
					if (rdv_q) begin
						if (func_q == bfpa_pkg::FUNC_ALLOC) begin
							if (rdata.len >= cnt_q && (!found_q || rdata.len < best_len_q)) begin
								found_q <= 1'b1;
								best_len_q <= rdata.len;
								best_start_q <= rdata.start;
								pos_q <= ridx;
							end
						end else if (!pos_found_q) begin
							if (rdata.start > base_q) begin
								pos_found_q <= 1'b1;
								pos_q <= ridx;
								nxt_q <= rdata;
								nxt_ok_q <= 1'b1;
							end else begin
								prev_q <= rdata;
							end
						end
					end
					if (!(i_q < nblk_q) && !rdv_q) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= S_DONE;
					if (func_q == bfpa_pkg::FUNC_ADD) begin
						ins_q <= '{start: base_q, len: cnt_q};
						k_q <= nblk_q;
						stop_q <= pos_q;
						nblk_q <= nblk_q + CntW'(1);
						total_q <= tsum[16] ? 16'hFFFF : tsum[15:0];
						state_q <= S_SHUP;
					end else if (func_q == bfpa_pkg::FUNC_ALLOC) begin
						if (!found_q) begin
							st_q <= bfpa_pkg::ST_NOFIT;
						end else begin
							pg_q <= best_start_q;
							total_q <= total_q - cnt_q;
							if (best_len_q > cnt_q) begin
								wr_we_q <= 1'b1;
								wr_addr_q <= pos_q[IdxW-1:0];
								wr_data_q <= '{start: best_start_q + cnt_q[14:0],
									len: best_len_q - cnt_q};
							end else begin
								k_q <= pos_q;
								nblk_q <= nblk_q - CntW'(1);
								stop_q <= nblk_q - CntW'(1);
								state_q <= S_NEXT;
							end
						end
					end else begin
						if (pm || nm) begin
							total_q <= tsum[16] ? 16'hFFFF : tsum[15:0];
							if (pm && nm) begin
								wr_we_q <= 1'b1;
								wr_addr_q <= IdxW'(pos_q - CntW'(1));
								wr_data_q <= '{start: prev_q.start, len: nlen[15:0]};
								k_q <= pos_q;
								nblk_q <= nblk_q - CntW'(1);
								stop_q <= nblk_q - CntW'(1);
								state_q <= S_NEXT;
							end else if (pm) begin
								wr_we_q <= 1'b1;
								wr_addr_q <= IdxW'(pos_q - CntW'(1));
								wr_data_q <= '{start: prev_q.start, len: plen[15:0]};
							end else begin
								wr_we_q <= 1'b1;
								wr_addr_q <= IdxW'(pos_q);
								wr_data_q <= '{start: cur_start, len: nlen[15:0]};
							end
						end else if (nblk_q >= CntW'(bfpa_pkg::MaxBlocks)) begin
							st_q <= bfpa_pkg::ST_FULL;
						end else begin
							ins_q <= '{start: base_q, len: cnt_q};
							k_q <= nblk_q;
							stop_q <= pos_q;
							nblk_q <= nblk_q + CntW'(1);
							total_q <= tsum[16] ? 16'hFFFF : tsum[15:0];
							state_q <= S_SHUP;
						end
					end
				end
				// shift down: read k+1, then write it to k
				S_NEXT: begin
					if (k_q < stop_q) begin
						state_q <= S_SHDN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SHDN: begin
					wr_we_q <= 1'b1;
					wr_addr_q <= IdxW'(k_q);
					wr_data_q <= rdata;
					k_q <= k_q + CntW'(1);
					state_q <= S_NEXT;
				end
				// shift up: read k-1, write to k, then place the new entry
				S_SHUP: begin
					if (k_q > stop_q) begin
						state_q <= S_FIX;
					end else begin
						wr_we_q <= 1'b1;
						wr_addr_q <= IdxW'(stop_q);
						wr_data_q <= ins_q;
						state_q <= S_DONE;
					end
				end
				S_FIX: begin
					wr_we_q <= 1'b1;
					wr_addr_q <= IdxW'(k_q);
					wr_data_q <= rdata;
					k_q <= k_q - CntW'(1);
					state_q <= S_SHUP;
				end
				// hand the result over once the output register is free
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						out_valid <= 1'b1;
						status <= st_q;
						page <= pg_q;
						pages_free <= total_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* rtl/core/best_fit_page_allocator_unit.sv */
// channel | valid    | stall     | fields
// in      | in_valid | in_stall  | func, base, count
// out     | out_valid| out_stall | status, page, pages_free
// One operation at a time: an accept step, a table scan through the table's single read
// port, a decide step and a write-out step; a shift on insert or remove reads and then
// writes each entry moved. Operations that skip the scan go from accept to write-out.
// Reset clears the block count and free total; table contents need no clearing.
// A held result stalls the next operation only at its final write-out.
`default_nettype none
module best_fit_page_allocator_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] func,
	input wire logic [14:0] base,
	input wire logic [15:0] count,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] status,
	output logic [14:0] page,
	output logic [15:0] pages_free
);
	bfpa_pkg::mem_req_t req;
	bfpa_pkg::blk_t rdata;

	bfpa_table u_table (.clk(clk), .req(req), .rdata(rdata));

	bfpa_seq u_seq (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.func(func), .base(base), .count(count), .out_valid(out_valid),
		.out_stall(out_stall), .status(status), .page(page),
		.pages_free(pages_free), .req(req), .rdata(rdata)
	);
endmodule
`default_nettype wire

/* rtl/core/bfpa_checker.sv */
`default_nettype none
module bfpa_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [1:0] status,
	input wire logic [14:0] page
);
	// a transfer in leaves the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall) else $error("not busy after transfer");
	// a failed operation reports page zero
	a_page: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != bfpa_pkg::ST_OK |-> page == '0) else $error("page on failure");
	// held result keeps its status
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)) else $error("result dropped");
endmodule

bind best_fit_page_allocator_unit bfpa_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status), .page(page)
);
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	typedef struct packed {
		logic [1:0] status;
		logic [14:0] page;
		logic [15:0] pages_free;
	} alloc_result_t;

	typedef struct {
		logic [1:0] fn;
		logic [14:0] pg;
		logic [15:0] cnt;
		bit known;
		alloc_result_t res;
	} op_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] func = bfpa_pkg::FUNC_NOP;
	logic [14:0] base = '0;
	logic [15:0] count = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [14:0] page;
	logic [15:0] pages_free;

	best_fit_page_allocator_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .base(base), .count(count),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .page(page), .pages_free(pages_free)
	);

	// free list mirror
	logic [14:0] free_start[bfpa_pkg::MaxBlocks];
	logic [15:0] free_len[bfpa_pkg::MaxBlocks];
	int free_cnt = 0;
	int unsigned page_total = 0;

	alloc_result_t pending_results[$];
	int mismatches = 0;
	longint cycles = 0;
	bit stim_done = 1'b0;
	op_row_t directed[$];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void credit_pages(int unsigned n);
		page_total = (page_total + n > 65535) ? 65535 : page_total + n;
	endfunction

	function automatic int slot_after(logic [14:0] b);
		int i;
		i = 0;
		while (i < free_cnt && free_start[i] <= b) i++;
		return i;
	endfunction

	function automatic void open_at(int pos);
		for (int k = free_cnt; k > pos; k--) begin
			free_start[k] = free_start[k-1];
			free_len[k] = free_len[k-1];
		end
		free_cnt++;
	endfunction

	function automatic void close_at(int pos);
		for (int k = pos; k + 1 < free_cnt; k++) begin
			free_start[k] = free_start[k+1];
			free_len[k] = free_len[k+1];
		end
		free_cnt--;
	endfunction

	// advance the free list by one operation
	function automatic alloc_result_t apply_page_op(logic [1:0] fn, logic [14:0] b,
			logic [15:0] n);
		alloc_result_t r;
		int pos, best, cs, cl;
		int unsigned best_len;
		bit found, pm, nm;
		r = '0;
		if (fn == bfpa_pkg::FUNC_NOP) begin
		end else if (n == 0) begin
			r.status = bfpa_pkg::ST_ZERO;
		end else if (fn == bfpa_pkg::FUNC_ADD) begin
			if (free_cnt >= bfpa_pkg::MaxBlocks) r.status = bfpa_pkg::ST_FULL;
			else begin
				pos = slot_after(b);
				open_at(pos);
				free_start[pos] = b;
				free_len[pos] = n;
				credit_pages(n);
			end
		end else if (fn == bfpa_pkg::FUNC_ALLOC) begin
			found = 0; best = 0; best_len = 0;
			if (n <= page_total && n <= bfpa_pkg::PageCount)
				for (int k = 0; k < free_cnt; k++)
					if (free_len[k] >= n && (!found || free_len[k] < best_len)) begin
						found = 1; best = k; best_len = free_len[k];
					end
			if (!found) r.status = bfpa_pkg::ST_NOFIT;
			else begin
				r.page = free_start[best];
				if (best_len > n) begin
					free_start[best] = free_start[best] + n[14:0];
					free_len[best] = 16'(best_len - n);
				end else close_at(best);
				page_total -= n;
			end
		end else begin
			pos = slot_after(b);
			cs = int'(b); cl = int'(n); pm = 0; nm = 0;
			if (pos > 0 && int'(free_start[pos-1]) + int'(free_len[pos-1]) == int'(b)
					&& int'(free_len[pos-1]) + int'(n) <= 65535) begin
				pm = 1; cs = int'(free_start[pos-1]); cl = int'(free_len[pos-1]) + int'(n);
			end
			if (pos < free_cnt && cs + cl == int'(free_start[pos])
					&& cl + int'(free_len[pos]) <= 65535) begin
				nm = 1; cl += int'(free_len[pos]);
			end
			if (pm && nm) begin
				free_len[pos-1] = 16'(cl); close_at(pos); credit_pages(n);
			end else if (pm) begin
				free_len[pos-1] = 16'(cl); credit_pages(n);
			end else if (nm) begin
				free_start[pos] = 15'(cs); free_len[pos] = 16'(cl); credit_pages(n);
			end else if (free_cnt >= bfpa_pkg::MaxBlocks) r.status = bfpa_pkg::ST_FULL;
			else begin
				open_at(pos);
				free_start[pos] = 15'(cs); free_len[pos] = 16'(cl); credit_pages(n);
			end
		end
		r.pages_free = page_total[15:0];
		return r;
	endfunction

	// hand one operation to the block
	task automatic send_op(logic [1:0] fn, logic [14:0] b, logic [15:0] n, bit known,
			alloc_result_t want);
		alloc_result_t r;
		int gap;
		gap = $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		r = apply_page_op(fn, b, n);
		if (known && r != want)
			$display("directed row disagrees with predictor: %h vs %h", want, r);
		pending_results.push_back(known ? want : r);
		func <= fn; base <= b; count <= n; in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	function automatic op_row_t row(logic [1:0] fn, int b, int n, bit known = 0,
			logic [1:0] st = bfpa_pkg::ST_OK, int pg = 0, int fp = 0);
		op_row_t o;
		o.fn = fn; o.pg = 15'(b); o.cnt = 16'(n); o.known = known;
		o.res.status = st; o.res.page = 15'(pg); o.res.pages_free = 16'(fp);
		return o;
	endfunction

	// stimulus
	initial begin
		int kind, n, b, pick;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		directed.push_back(row(bfpa_pkg::FUNC_ALLOC, 0, 1, 1, bfpa_pkg::ST_NOFIT, 0, 0));
		directed.push_back(row(bfpa_pkg::FUNC_ADD, 0, 0, 1, bfpa_pkg::ST_ZERO, 0, 0));
		directed.push_back(row(bfpa_pkg::FUNC_NOP, 32767, 65535, 1, bfpa_pkg::ST_OK, 0, 0));
		directed.push_back(row(bfpa_pkg::FUNC_ADD, 100, 50, 1, bfpa_pkg::ST_OK, 0, 50));
		directed.push_back(row(bfpa_pkg::FUNC_ADD, 100, 10, 1, bfpa_pkg::ST_OK, 0, 60));
		directed.push_back(row(bfpa_pkg::FUNC_ALLOC, 0, 10, 1, bfpa_pkg::ST_OK, 100, 50));
		directed.push_back(row(bfpa_pkg::FUNC_ALLOC, 0, 51));
		directed.push_back(row(bfpa_pkg::FUNC_REL, 100, 10));
		directed.push_back(row(bfpa_pkg::FUNC_REL, 160, 5));
		directed.push_back(row(bfpa_pkg::FUNC_REL, 90, 10));
		directed.push_back(row(bfpa_pkg::FUNC_ADD, 32767, 65535));
		directed.push_back(row(bfpa_pkg::FUNC_ALLOC, 0, 32768));
		directed.push_back(row(bfpa_pkg::FUNC_ALLOC, 0, 32769));
		directed.push_back(row(bfpa_pkg::FUNC_ALLOC, 0, 65535));
		directed.push_back(row(bfpa_pkg::FUNC_REL, 32767, 0, 1, bfpa_pkg::ST_ZERO, 0, 0));
		directed.push_back(row(bfpa_pkg::FUNC_ALLOC, 5, 0, 1, bfpa_pkg::ST_ZERO, 0, 0));
		directed.push_back(row(bfpa_pkg::FUNC_REL, 0, 65535));
		directed.push_back(row(bfpa_pkg::FUNC_REL, 5000, 65535));
		directed.push_back(row(bfpa_pkg::FUNC_ALLOC, 0, 1));
		directed.push_back(row(bfpa_pkg::FUNC_NOP, 0, 0));
		foreach (directed[i]) begin
			if (directed[i].known && i >= 14)
				directed[i].res.pages_free = 16'(page_total);
			send_op(directed[i].fn, directed[i].pg, directed[i].cnt, directed[i].known,
				directed[i].res);
		end
		// hold until every result is in, then refill to fill the table
		drain();
		for (int i = 0; i < 70; i++)
			send_op(bfpa_pkg::FUNC_ADD, 15'($urandom_range(0, 32767)),
				16'($urandom_range(1, 65535)), 0, '0);
		send_op(bfpa_pkg::FUNC_REL, 15'd12345, 16'd3, 0, '0);

		// random mixed traffic, waiting for all results after the first 700 operations
		for (int i = 0; i < 1360; i++) begin
			if (i == 700) drain();
			kind = $urandom_range(0, 99);
			pick = $urandom_range(0, 3);
			n = (pick == 0) ? $urandom_range(0, 65535) :
				(pick == 1) ? $urandom_range(0, 4) : $urandom_range(1, 600);
			b = $urandom_range(0, 32767);
			if (kind < 40) begin
				if (free_cnt > 0 && $urandom_range(0, 1)) begin
					pick = $urandom_range(0, free_cnt - 1);
					b = (free_start[pick] + free_len[pick]) & 16'h7fff;
					if ($urandom_range(0, 1)) b = (free_start[pick] - n) & 16'h7fff;
				end
				send_op(bfpa_pkg::FUNC_REL, 15'(b), 16'(n), 0, '0);
			end else if (kind < 80) send_op(bfpa_pkg::FUNC_ALLOC, 15'(b), 16'(n), 0, '0);
			else if (kind < 96) send_op(bfpa_pkg::FUNC_ADD, 15'(b), 16'(n), 0, '0);
			else send_op(bfpa_pkg::FUNC_NOP, 15'(b), 16'(n), 0, '0);
		end
		drain();
		stim_done = 1'b1;
	end

	// random stall on the result side
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = $urandom_range(0, 3);
			if ($urandom_range(0, 3) == 0) hold = 0;
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			@(negedge clk);
		end
	end

	// compare each transfer with the oldest expectation
	always @(posedge clk) begin
		alloc_result_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got.status = status; got.page = page; got.pages_free = pages_free;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("status %0d/%0d page %0d/%0d free %0d/%0d (exp/act)",
							want.status, status, want.page, page,
							want.pages_free, pages_free);
				end
			end
		end
	end

	// end of run and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (stim_done) begin
			if (mismatches == 0 && pending_results.size() == 0)
				$display("best_fit_page_allocator_unit: match");
			else
				$display("best_fit_page_allocator_unit: mismatch");
			$finish;
		end else if (cycles > 2000000) begin
			$display("best_fit_page_allocator_unit: mismatch");
			$finish;
		end
	end
endmodule
`default_nettype wire
